FILE: hdl/knn_topk_weighted_vote_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the k-nearest-neighbor vote block
// Implication checks sampled on the rising clock edge, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef KNN_TOPK_WEIGHTED_VOTE_ASSERT_SVH
`define KNN_TOPK_WEIGHTED_VOTE_ASSERT_SVH

// Same-cycle implication.
`define KNNV_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("knnv assertion failed");

// Next-cycle implication.
`define KNNV_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("knnv assertion failed");

`endif

FILE: hdl/knnv_pkg.sv
// ---------------------------------------------------------------------------
// knnv_pkg
// Transfer types and fixed field widths of the k-nearest-neighbor vote block.
// ---------------------------------------------------------------------------
`default_nettype none

package knnv_pkg;

    localparam int DIST_W  = 16;
    localparam int LABEL_W = 4;
    localparam int COUNT_W = 3;

    typedef struct packed {
        logic [DIST_W-1:0]  cand_distance;
        logic [LABEL_W-1:0] cand_label;
        logic               has_candidate;
        logic               end_of_query;
    } item_t;

    typedef struct packed {
        logic [LABEL_W-1:0] predicted_class;
        logic [COUNT_W-1:0] kept_count;
    } result_t;

endpackage

`default_nettype wire

FILE: hdl/knnv_front.sv
// ---------------------------------------------------------------------------
// knnv_front
// Sorted top-K list with compare-and-shift insertion; pushes a
// label snapshot and fill count to the queue on every end-of-query transfer.
// ---------------------------------------------------------------------------
`default_nettype none

module knnv_front #(
    parameter int TOP_K       = 5,
    parameter int NUM_CLASSES = 10,
    parameter int DIST_BITS   = 16,
    parameter int FILL_BITS   = 3
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   accept,
    input  wire knnv_pkg::item_t                        item,
    output logic                                        push,
    output logic [TOP_K*knnv_pkg::LABEL_W-1:0]          snap_labels,
    output logic [FILL_BITS-1:0]                        snap_count
);

    localparam int LW = knnv_pkg::LABEL_W;

    logic [DIST_BITS-1:0] dist_reg   [TOP_K];
    logic [LW-1:0]        label_reg  [TOP_K];
    logic [DIST_BITS-1:0] dist_next  [TOP_K];
    logic [LW-1:0]        label_next [TOP_K];
    logic [FILL_BITS-1:0] fill_reg, fill_next;

    logic [DIST_BITS-1:0] cand_d;
    logic                 label_ok;
    logic                 list_full;
    logic                 do_insert;
    logic [TOP_K-1:0]     keep;

    assign cand_d    = DIST_BITS'(item.cand_distance);
    assign label_ok  = ({1'b0, item.cand_label} < (LW+1)'(NUM_CLASSES));
    assign list_full = (fill_reg == FILL_BITS'(TOP_K));
    assign do_insert = accept && item.has_candidate && label_ok &&
                       (!list_full || (cand_d < dist_reg[TOP_K-1]));

    // Valid entries at or below the new distance stay; the list is sorted,
    // so these form a prefix and the candidate lands just behind it.
    genvar gi;
    generate
        for (gi = 0; gi < TOP_K; gi++) begin : g_slot
            assign keep[gi] = (FILL_BITS'(gi) < fill_reg) && (dist_reg[gi] <= cand_d);
            if (gi == 0) begin : g_head
                always_comb begin
                    if (keep[gi]) begin
                        dist_next[gi]  = dist_reg[gi];
                        label_next[gi] = label_reg[gi];
                    end else begin
                        dist_next[gi]  = cand_d;
                        label_next[gi] = item.cand_label;
                    end
                end
            end else begin : g_body
                always_comb begin
                    if (keep[gi]) begin
                        dist_next[gi]  = dist_reg[gi];
                        label_next[gi] = label_reg[gi];
                    end else if (keep[gi-1]) begin
                        dist_next[gi]  = cand_d;
                        label_next[gi] = item.cand_label;
                    end else begin
                        dist_next[gi]  = dist_reg[gi-1];
                        label_next[gi] = label_reg[gi-1];
                    end
                end
            end
            assign snap_labels[gi*LW +: LW] = do_insert ? label_next[gi] : label_reg[gi];
        end
    endgenerate

    assign fill_next  = (do_insert && !list_full) ? fill_reg + FILL_BITS'(1) : fill_reg;
    assign push       = accept && item.end_of_query;
    assign snap_count = fill_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (push) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_insert) begin
            for (int i = 0; i < TOP_K; i++) begin
                dist_reg[i]  <= dist_next[i];
                label_reg[i] <= label_next[i];
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/knnv_queue.sv
// ---------------------------------------------------------------------------
// knnv_queue
// Two-entry queue of query snapshots between the list and the vote pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

`include "knn_topk_weighted_vote_assert.svh"

module knnv_queue #(
    parameter int WIDTH = 23
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      head_data
);

    logic [WIDTH-1:0] head_reg, tail_reg;
    logic [1:0]       count_reg, count_next;
    logic [1:0]       count_after_pop;

    assign full            = (count_reg == 2'd2);
    assign not_empty       = (count_reg != 2'd0);
    assign head_data       = head_reg;
    assign count_after_pop = count_reg - {1'b0, pop};
    assign count_next      = count_after_pop + {1'b0, push};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Advance tail into head on pop, then drop the new entry into the first free slot.
    always_ff @(posedge aclk) begin
        if (push && (count_after_pop == 2'd0)) begin
            head_reg <= push_data;
        end else if (pop) begin
            head_reg <= tail_reg;
        end
        if (push && (count_after_pop != 2'd0)) begin
            tail_reg <= push_data;
        end
    end

    `KNNV_ASSERT_IMPL(a_no_push_full, aclk, aresetn, push, !full)
    `KNNV_ASSERT_IMPL(a_no_pop_empty, aclk, aresetn, pop, not_empty)
    `KNNV_ASSERT_NEXT(a_push_only_grows, aclk, aresetn, push && !pop,
                      count_reg == $past(count_reg) + 2'd1)
    `KNNV_ASSERT_NEXT(a_pop_only_shrinks, aclk, aresetn, pop && !push,
                      count_reg == $past(count_reg) - 2'd1)

endmodule

`default_nettype wire

FILE: hdl/knnv_back.sv
// ---------------------------------------------------------------------------
// knnv_back
// Vote pipeline: per-class rank-weighted scores, then first-maximum select
// into the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module knnv_back #(
    parameter int TOP_K       = 5,
    parameter int NUM_CLASSES = 10,
    parameter int FILL_BITS   = 3
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              snap_valid,
    input  wire logic [TOP_K*knnv_pkg::LABEL_W-1:0] snap_labels,
    input  wire logic [FILL_BITS-1:0]              snap_count,
    output logic                                   snap_pop,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output knnv_pkg::result_t                      m_result
);

    localparam int LW = knnv_pkg::LABEL_W;
    localparam int CW = knnv_pkg::COUNT_W;
    localparam int SB = $clog2(TOP_K * (TOP_K + 1) / 2 + 1);

    logic [SB-1:0]        score_next [NUM_CLASSES];
    logic [SB-1:0]        score_reg  [NUM_CLASSES];
    logic [FILL_BITS-1:0] cnt_reg;
    logic                 s1_valid_reg;
    logic                 m_valid_reg;
    knnv_pkg::result_t    result_reg;
    knnv_pkg::result_t    result_next;
    logic [NUM_CLASSES-1:0] winner;
    logic                 out_free;
    logic                 s1_advance;

    assign out_free   = !m_valid_reg || m_ready;
    assign s1_advance = !s1_valid_reg || out_free;
    assign snap_pop   = snap_valid && s1_advance;
    assign m_valid    = m_valid_reg;
    assign m_result   = result_reg;

    // Entry at rank r adds TOP_K - r to its class.
    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            score_next[c] = '0;
            for (int i = 0; i < TOP_K; i++) begin
                if ((FILL_BITS'(i) < snap_count) &&
                    (snap_labels[i*LW +: LW] == LW'(c))) begin
                    score_next[c] = score_next[c] + SB'(TOP_K - i);
                end
            end
        end
    end

    // A class wins if it beats every lower class and ties or beats every higher one.
    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            winner[c] = 1'b1;
            for (int j = 0; j < NUM_CLASSES; j++) begin
                if ((j < c) && !(score_reg[c] > score_reg[j])) begin
                    winner[c] = 1'b0;
                end
                if ((j > c) && (score_reg[c] < score_reg[j])) begin
                    winner[c] = 1'b0;
                end
            end
        end
        result_next.predicted_class = '0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (winner[c]) begin
                result_next.predicted_class = LW'(c);
            end
        end
        result_next.kept_count = CW'(cnt_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_advance) begin
                s1_valid_reg <= snap_valid;
            end
            if (out_free) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_pop) begin
            score_reg <= score_next;
            cnt_reg   <= snap_count;
        end
        if (out_free && s1_valid_reg) begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/knn_topk_weighted_vote.sv
// ---------------------------------------------------------------------------
// knn_topk_weighted_vote
// Streaming top-K nearest-neighbor list with a rank-weighted class vote.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel carries one item per transfer: a candidate (distance, label,
//   has_candidate) and/or an end_of_query marker. Candidates with a label at
//   or above NUM_CLASSES are dropped. One item per clock if s_ready is high.
//   m_ channel gives one result per end_of_query item: the winning class
//   (lowest class on a tie, class 0 for an empty query) and the number of
//   voting entries, wrapped to 3 bits.
//   Path: an end-of-query snapshot passes through the snapshot queue, the
//   score register and the output register before it shows on m_valid.
//   Throughput: one item per cycle while s_ready is high, through the
//   compare-and-shift insertion over the K list slots; back-to-back queries
//   also run at one per cycle in the vote pipeline while m_ready is high.
//   Stall: when m_ready is low the vote pipeline holds and the two-entry
//   snapshot queue fills; s_ready drops only while that queue is full.
//   Reset: aresetn (synchronous, active low) empties the list, the queue and
//   the pipeline; no result is pending afterwards.
// ---------------------------------------------------------------------------
`default_nettype none

module knn_topk_weighted_vote #(
    parameter int TOP_K       = 5,
    parameter int NUM_CLASSES = 10,
    parameter int DIST_BITS   = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire knnv_pkg::item_t   s_item,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output knnv_pkg::result_t      m_result
);

    localparam int LW        = knnv_pkg::LABEL_W;
    localparam int FILL_BITS = $clog2(TOP_K + 1);
    localparam int SNAP_W    = TOP_K * LW + FILL_BITS;

    logic                    accept;
    logic                    push;
    logic [TOP_K*LW-1:0]     front_labels;
    logic [FILL_BITS-1:0]    front_count;
    logic                    queue_full;
    logic                    queue_not_empty;
    logic                    queue_pop;
    logic [SNAP_W-1:0]       queue_head;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;

    knnv_front #(
        .TOP_K       (TOP_K),
        .NUM_CLASSES (NUM_CLASSES),
        .DIST_BITS   (DIST_BITS),
        .FILL_BITS   (FILL_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .item        (s_item),
        .push        (push),
        .snap_labels (front_labels),
        .snap_count  (front_count)
    );

    knnv_queue #(
        .WIDTH (SNAP_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({front_labels, front_count}),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .head_data (queue_head)
    );

    knnv_back #(
        .TOP_K       (TOP_K),
        .NUM_CLASSES (NUM_CLASSES),
        .FILL_BITS   (FILL_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .snap_valid  (queue_not_empty),
        .snap_labels (queue_head[SNAP_W-1:FILL_BITS]),
        .snap_count  (queue_head[FILL_BITS-1:0]),
        .snap_pop    (queue_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result)
    );

endmodule

`default_nettype wire

FILE: sim/knn_topk_weighted_vote_tb.sv
// ---------------------------------------------------------------------------
// knn_topk_weighted_vote_tb
// Self-checking bench for the top-K nearest-neighbor vote block. A queue of
// candidate and end-of-query items feeds a valid/ready driver with random
// idle bursts. Each accepted transfer updates a local copy of the sorted
// neighbor list, and every end-of-query predicts a vote result. A monitor
// with random back-pressure compares each result transfer with the oldest
// prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module knn_topk_weighted_vote_tb;

    localparam int TOP_K        = 5;
    localparam int NUM_CLASSES  = 10;
    localparam int DIST_BITS    = 16;
    localparam int RANDOM_ITEMS = 1000;
    localparam int TAIL_ITEMS   = 80;
    localparam int DRAIN_CYCLES = 12;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    knnv_pkg::item_t   s_item  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    knnv_pkg::result_t m_result;

    knn_topk_weighted_vote #(
        .TOP_K       (TOP_K),
        .NUM_CLASSES (NUM_CLASSES),
        .DIST_BITS   (DIST_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Neighbor list as the block should hold it
    logic [knnv_pkg::DIST_W-1:0]  nb_dist  [TOP_K];
    logic [knnv_pkg::LABEL_W-1:0] nb_label [TOP_K];
    int                           nb_fill = 0;

    knnv_pkg::item_t   vote_items[$];
    knnv_pkg::result_t expected_votes[$];

    int n_total     = 0;
    int n_accepted  = 0;
    int n_queries   = 0;
    int n_checked   = 0;
    int mismatches  = 0;

    int src_gap  = 0;
    int src_rate = 0;
    int snk_gap  = 0;
    int snk_rate = 0;

    // Insert the candidate, then on end of query score the list and clear it.
    function automatic void predict_vote(knnv_pkg::item_t it);
        int pos;
        int i;
        int win;
        int unsigned score [NUM_CLASSES];
        knnv_pkg::result_t r;
        if (it.has_candidate && it.cand_label < NUM_CLASSES) begin
            pos = -1;
            if (nb_fill < TOP_K) begin
                pos = nb_fill;
                nb_fill++;
            end else if (it.cand_distance < nb_dist[TOP_K-1]) begin
                pos = TOP_K - 1;
            end
            if (pos >= 0) begin
                // equal distances stay ahead of the newcomer
                while (pos > 0 && nb_dist[pos-1] > it.cand_distance) begin
                    nb_dist[pos]  = nb_dist[pos-1];
                    nb_label[pos] = nb_label[pos-1];
                    pos--;
                end
                nb_dist[pos]  = it.cand_distance;
                nb_label[pos] = it.cand_label;
            end
        end
        if (it.end_of_query) begin
            for (i = 0; i < NUM_CLASSES; i++)
                score[i] = 0;
            for (i = 0; i < nb_fill; i++)
                score[nb_label[i]] += TOP_K - i;
            win = 0;
            for (i = 1; i < NUM_CLASSES; i++)
                if (score[i] > score[win])
                    win = i;
            r.predicted_class = knnv_pkg::LABEL_W'(win);
            r.kept_count      = knnv_pkg::COUNT_W'(nb_fill);
            expected_votes.push_back(r);
            nb_fill = 0;
        end
    endfunction

    function automatic knnv_pkg::item_t mk_item(int d, int l, bit has, bit eoq);
        knnv_pkg::item_t it;
        it.cand_distance = knnv_pkg::DIST_W'(d);
        it.cand_label    = knnv_pkg::LABEL_W'(l);
        it.has_candidate = has;
        it.end_of_query  = eoq;
        return it;
    endfunction

    // Distance styles: full range, tiny range for ties, extremes, narrow band.
    function automatic knnv_pkg::item_t rand_candidate(int style, bit eoq);
        int d;
        int l;
        case (style)
            0: d = $urandom_range(0, 65535);
            1: d = $urandom_range(0, 7);
            2: begin
                case ($urandom_range(0, 3))
                    0: d = 0;
                    1: d = 1;
                    2: d = 65534;
                    default: d = 65535;
                endcase
            end
            default: d = $urandom_range(1000, 1100);
        endcase
        if ($urandom_range(0, 7) == 0)
            l = $urandom_range(NUM_CLASSES, 15);
        else
            l = $urandom_range(0, NUM_CLASSES - 1);
        return mk_item(d, l, 1'b1, eoq);
    endfunction

    // Source side: hold the item until the transfer, idle only between items.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_item  <= '0;
            src_gap = 0;
        end else begin
            if ($urandom_range(0, 127) == 0)
                src_rate = $urandom_range(0, 2);
            if (s_valid && s_ready) begin
                predict_vote(s_item);
                n_accepted++;
                if (s_item.end_of_query)
                    n_queries++;
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (vote_items.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (vote_items.size() > TAIL_ITEMS && src_rate != 0 &&
                             $urandom_range(0, src_rate == 1 ? 15 : 3) == 0) begin
                    src_gap = $urandom_range(0, 16);
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_item  <= vote_items.pop_front();
                end
            end
        end
    end

    // Result side: check each transfer, stall in random bursts.
    always @(posedge aclk) begin
        knnv_pkg::result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            snk_gap = 0;
        end else begin
            if ($urandom_range(0, 127) == 0)
                snk_rate = $urandom_range(0, 2);
            if (m_valid && m_ready) begin
                if (expected_votes.size() == 0) begin
                    if (mismatches < 10)
                        $display("[%0t] unexpected result: class %0d count %0d",
                                 $realtime, m_result.predicted_class,
                                 m_result.kept_count);
                    mismatches++;
                end else begin
                    want = expected_votes.pop_front();
                    n_checked++;
                    if (m_result.predicted_class !== want.predicted_class ||
                        m_result.kept_count !== want.kept_count) begin
                        if (mismatches < 10)
                            $display(
                                "[%0t] result %0d: class exp %0d got %0d, cnt exp %0d got %0d",
                                $realtime, n_checked, want.predicted_class,
                                m_result.predicted_class, want.kept_count,
                                m_result.kept_count);
                        mismatches++;
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                m_ready <= 1'b0;
            end else if (vote_items.size() > TAIL_ITEMS && snk_rate != 0 &&
                         $urandom_range(0, snk_rate == 1 ? 15 : 3) == 0) begin
                snk_gap = $urandom_range(0, 16);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int counted;
        int qlen;
        int style;
        int j;
        // empty query, then an item that does nothing
        vote_items.push_back(mk_item(0, 0, 1'b0, 1'b1));
        vote_items.push_back(mk_item(16'hFFFF, 4'hF, 1'b0, 1'b0));
        // candidate and end marker together
        vote_items.push_back(mk_item(16'hFFFF, 9, 1'b1, 1'b1));
        // equal distances keep arrival order; out-of-range labels dropped
        vote_items.push_back(mk_item(100, 3, 1'b1, 1'b0));
        vote_items.push_back(mk_item(100, 7, 1'b1, 1'b0));
        vote_items.push_back(mk_item(50, 10, 1'b1, 1'b0));
        vote_items.push_back(mk_item(100, 15, 1'b1, 1'b0));
        vote_items.push_back(mk_item(0, 7, 1'b0, 1'b1));
        // full list: equal to the last is refused, closer replaces it
        vote_items.push_back(mk_item(10, 1, 1'b1, 1'b0));
        vote_items.push_back(mk_item(20, 2, 1'b1, 1'b0));
        vote_items.push_back(mk_item(30, 3, 1'b1, 1'b0));
        vote_items.push_back(mk_item(40, 4, 1'b1, 1'b0));
        vote_items.push_back(mk_item(50, 5, 1'b1, 1'b0));
        vote_items.push_back(mk_item(50, 6, 1'b1, 1'b0));
        vote_items.push_back(mk_item(45, 6, 1'b1, 1'b0));
        vote_items.push_back(mk_item(0, 8, 1'b1, 1'b1));
        // three-way score tie goes to the lowest class
        vote_items.push_back(mk_item(1, 6, 1'b1, 1'b0));
        vote_items.push_back(mk_item(2, 2, 1'b1, 1'b0));
        vote_items.push_back(mk_item(3, 8, 1'b1, 1'b0));
        vote_items.push_back(mk_item(4, 8, 1'b1, 1'b0));
        vote_items.push_back(mk_item(5, 2, 1'b1, 1'b1));
        // distance extremes
        vote_items.push_back(mk_item(16'hFFFF, 9, 1'b1, 1'b0));
        vote_items.push_back(mk_item(0, 0, 1'b1, 1'b0));
        vote_items.push_back(mk_item(16'hAAAA, 1, 1'b1, 1'b0));
        vote_items.push_back(mk_item(16'h5555, 5, 1'b1, 1'b1));

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            qlen  = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
                                                : $urandom_range(0, 8);
            style = $urandom_range(0, 3);
            for (j = 0; j < qlen; j++) begin
                if ($urandom_range(0, 15) == 0)
                    vote_items.push_back(mk_item($urandom_range(0, 65535),
                                                 $urandom_range(0, 15), 1'b0, 1'b0));
                vote_items.push_back(rand_candidate(style, 1'b0));
                counted++;
            end
            if ($urandom_range(0, 1) == 0)
                vote_items.push_back(rand_candidate(style, 1'b1));
            else
                vote_items.push_back(mk_item($urandom_range(0, 65535),
                                             $urandom_range(0, 15), 1'b0, 1'b1));
            counted++;
        end
        n_total = vote_items.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (n_accepted < n_total || expected_votes.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Drove %0d items over %0d queries under random idle and stall.",
                 n_accepted, n_queries);
        $display("Checked %0d vote results, %0d mismatches.", n_checked, mismatches);
        if (mismatches == 0 && expected_votes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out with %0d results outstanding", expected_votes.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: knn_topk_weighted_vote.f
+incdir+hdl
hdl/knnv_pkg.sv
hdl/knnv_front.sv
hdl/knnv_queue.sv
hdl/knnv_back.sv
hdl/knn_topk_weighted_vote.sv
sim/knn_topk_weighted_vote_tb.sv
